[rtl/gradient_fill_pixel_generator_assert.svh]
// ----------------------------------------------------------------------------
// Gradient fill assertion macros
// Clocked assertion wrappers shared by the gradient fill RTL.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_FILL_PIXEL_GENERATOR_ASSERT_SVH
`define GRADIENT_FILL_PIXEL_GENERATOR_ASSERT_SVH

// assertion on an explicit clock and synchronous reset
`define GFPG_ASSERT_ON(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// assertion on the block clock clk and reset rst
`define GFPG_ASSERT(lbl, prop, msg) `GFPG_ASSERT_ON(lbl, clk, rst, prop, msg)

`endif

[rtl/gfpg_pkg.sv]
// ----------------------------------------------------------------------------
// Gradient fill package
// Shared widths, register map, mode codes and beat types.
// ----------------------------------------------------------------------------
package gfpg_pkg;

  localparam int GFPG_MAX_DIM = 4096;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int COL_W   = 24;
  localparam int RS_W    = 16;
  localparam int FRAC_W  = 17;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 3;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // mode codes
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_HORIZ    = 3'd1;
  localparam logic [2:0] MODE_VERT     = 3'd2;
  localparam logic [2:0] MODE_BILINEAR = 3'd3;
  localparam logic [2:0] MODE_RADIAL   = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_COLOUR_A = 3'd3;
  localparam logic [IDX_W-1:0] REG_COLOUR_B = 3'd4;
  localparam logic [IDX_W-1:0] REG_COLOUR_C = 3'd5;
  localparam logic [IDX_W-1:0] REG_COLOUR_D = 3'd6;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [COL_W-1:0] colour_a;
    logic [COL_W-1:0] colour_b;
    logic [COL_W-1:0] colour_c;
    logic [COL_W-1:0] colour_d;
    logic [RS_W-1:0]  radius_scale;
  } cfg_t;

  // modes that produce a pixel
  function automatic logic mode_active(logic [2:0] m);
    return (m == MODE_HORIZ) || (m == MODE_VERT) || (m == MODE_BILINEAR) ||
           (m == MODE_RADIAL);
  endfunction

endpackage

[rtl/gfpg_regs.sv]
// ----------------------------------------------------------------------------
// Gradient fill register file
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module gfpg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfpg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output gfpg_pkg::cfg_t              cfg
);
  import gfpg_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_NONE;
      cfg.frame_width  <= DIM_W'(1);
      cfg.frame_height <= DIM_W'(1);
      cfg.colour_a     <= '0;
      cfg.colour_b     <= '0;
      cfg.colour_c     <= '0;
      cfg.colour_d     <= '0;
      cfg.radius_scale <= RS_W'(2048);
    end else if (wr) begin
      unique case (idx)
        REG_MODE:     cfg.mode         <= pwdata[2:0];
        REG_WIDTH:    cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:   cfg.frame_height <= pwdata[DIM_W-1:0];
        REG_COLOUR_A: cfg.colour_a     <= pwdata[COL_W-1:0];
        REG_COLOUR_B: cfg.colour_b     <= pwdata[COL_W-1:0];
        REG_COLOUR_C: cfg.colour_c     <= pwdata[COL_W-1:0];
        REG_COLOUR_D: cfg.colour_d     <= pwdata[COL_W-1:0];
        REG_RADIUS:   cfg.radius_scale <= pwdata[RS_W-1:0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_MODE:     prdata = 32'(cfg.mode);
      REG_WIDTH:    prdata = 32'(cfg.frame_width);
      REG_HEIGHT:   prdata = 32'(cfg.frame_height);
      REG_COLOUR_A: prdata = 32'(cfg.colour_a);
      REG_COLOUR_B: prdata = 32'(cfg.colour_b);
      REG_COLOUR_C: prdata = 32'(cfg.colour_c);
      REG_COLOUR_D: prdata = 32'(cfg.colour_d);
      REG_RADIUS:   prdata = 32'(cfg.radius_scale);
    endcase
  end

endmodule

[rtl/gfpg_sqrt.sv]
// ----------------------------------------------------------------------------
// Gradient fill square root
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module gfpg_sqrt #(
  parameter int RW = 60,
  parameter int SW = 56
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [RW-1:0]   radicand,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW/2-1:0] root,
  output logic [SW-1:0]   out_side
);
  localparam int RTW  = RW / 2;
  localparam int REMW = RTW + 2;

  logic            vld  [RTW+1];
  logic [RW-1:0]   rad  [RTW+1];
  logic [REMW-1:0] rem  [RTW+1];
  logic [RTW-1:0]  rt   [RTW+1];
  logic [SW-1:0]   side [RTW+1];

  // input stage
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
    rad[0]  <= radicand;
    rem[0]  <= '0;
    rt[0]   <= '0;
    side[0] <= in_side;
  end

  // one root bit per stage
  for (genvar i = 1; i <= RTW; i++) begin : g_stage
    logic [REMW-1:0] t;
    logic [REMW-1:0] trial;
    logic            ge;
    assign t     = {rem[i-1][REMW-3:0], rad[i-1][RW-1:RW-2]};
    assign trial = {rt[i-1], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else     vld[i] <= vld[i-1];
      rem[i]  <= ge ? t - trial : t;
      rt[i]   <= {rt[i-1][RTW-2:0], ge};
      rad[i]  <= rad[i-1] << 2;
      side[i] <= side[i-1];
    end
  end

  assign out_valid = vld[RTW];
  assign root      = rt[RTW];
  assign out_side  = side[RTW];

endmodule

[rtl/gfpg_div.sv]
// ----------------------------------------------------------------------------
// Gradient fill divider
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
`include "gradient_fill_pixel_generator_assert.svh"

module gfpg_div #(
  parameter int NW = 28,
  parameter int DW = 13,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          ovf
);
  logic          vld  [QW+1];
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic          ovfs [QW+1];
  logic [DW-1:0] hi;
  logic          ovf_in;

  // upper numerator bits must already sit below the divisor
  assign hi     = DW'(num[NW-1:QW]);
  assign ovf_in = hi >= den;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
    rem[0]  <= hi;
    low[0]  <= num[QW-1:0];
    quo[0]  <= '0;
    ovfs[0] <= ovf_in;
  end

  // one quotient bit per stage
  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {rem[i-1], low[i-1][QW-1]};
    assign diff = t - {1'b0, den};
    assign ge   = t >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else     vld[i] <= vld[i-1];
      rem[i]  <= ge ? diff[DW-1:0] : t[DW-1:0];
      low[i]  <= low[i-1] << 1;
      quo[i]  <= {quo[i-1][QW-2:0], ge};
      ovfs[i] <= ovfs[i-1];
    end
  end

  assign out_valid = vld[QW];
  assign quot      = quo[QW];
  assign ovf       = ovfs[QW];

  // checks
  `GFPG_ASSERT(a_div_latency, in_valid |-> ##(QW+1) out_valid, "divider lost a beat")
  `GFPG_ASSERT(a_div_ovf, in_valid && ovf_in |-> ##(QW+1) ovf, "divider overflow flag lost")
  `GFPG_ASSERT(a_div_rem, out_valid && !ovf && den != '0 |-> rem[QW] < den, "remainder too big")

endmodule

[rtl/gfpg_blend.sv]
// ----------------------------------------------------------------------------
// Gradient fill blender
// Three-stage colour blend with rounding to RGB888.
// ----------------------------------------------------------------------------
module gfpg_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [gfpg_pkg::FRAC_W-1:0] fx,
  input  logic [gfpg_pkg::FRAC_W-1:0] fy,
  input  logic [gfpg_pkg::FRAC_W-1:0] fr,
  input  gfpg_pkg::cfg_t              cfg,
  output logic                        done,
  output gfpg_pkg::result_t           result
);
  import gfpg_pkg::*;

  function automatic logic [7:0] chan(logic [COL_W-1:0] rgb, int k);
    return rgb[23 - 8*k -: 8];
  endfunction

  logic [FRAC_W-1:0] g;
  logic [COL_W-1:0]  col_b;
  logic              bil;
  logic [23:0]       lft [3];
  logic [23:0]       rgt [3];

  logic              v1, v2;
  logic              bil1, bil2;
  logic [23:0]       lft1 [3];
  logic [23:0]       rgt1 [3];
  logic [FRAC_W-1:0] fx1;
  logic [40:0]       pl2 [3];
  logic [40:0]       pr2 [3];
  logic [23:0]       lft2 [3];
  logic [7:0]        ch [3];

  // first blend: along y for corners, else the single blend
  always_comb begin
    bil   = cfg.mode == MODE_BILINEAR;
    col_b = bil ? cfg.colour_c : cfg.colour_b;
    if (cfg.mode == MODE_HORIZ)     g = fx;
    else if (cfg.mode == MODE_VERT) g = fy;
    else if (bil)                   g = fy;
    else                            g = fr;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [24:0] sl, sr, sum3;
    logic [40:0] tot;
    assign sl = 25'(chan(cfg.colour_a, k)) * 25'(FRAC_ONE - g) + 25'(chan(col_b, k)) * 25'(g);
    assign sr = 25'(chan(cfg.colour_b, k)) * 25'(FRAC_ONE - fy) +
                25'(chan(cfg.colour_d, k)) * 25'(fy);
    assign lft[k] = sl[23:0];
    assign rgt[k] = sr[23:0];
    // final rounding
    assign tot    = pl2[k] + pr2[k] + 41'h0080000000;
    assign sum3   = 25'(lft2[k]) + 25'h8000;
    assign ch[k]  = bil2 ? tot[39:32] : sum3[23:16];

    always_ff @(posedge clk) begin
      lft1[k] <= lft[k];
      rgt1[k] <= rgt[k];
      // second blend products along x
      pl2[k]  <= 41'(lft1[k]) * 41'(FRAC_ONE - fx1);
      pr2[k]  <= 41'(rgt1[k]) * 41'(fx1);
      lft2[k] <= lft1[k];
    end
  end

  // stage valids and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
    bil1         <= bil;
    fx1          <= fx;
    bil2         <= bil1;
    result.red   <= ch[0];
    result.green <= ch[1];
    result.blue  <= ch[2];
  end

endmodule

[rtl/gradient_fill_pixel_generator.sv]
// ----------------------------------------------------------------------------
// Gradient fill pixel generator
// Returns the horizontal, vertical, bilinear or radial gradient colour of a
// pixel coordinate, one pixel per clock.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  pixel     in         start, busy            pixel_x, pixel_y
//  result    out        done (one cycle)       red, green, blue
//  config    in/out     psel, penable, pready  paddr, pwdata, prdata
//
//  a pixel is taken every clock; busy stays low
//  done is reached from the accepting edge through three front stages, the
//  31-stage square root, the numerator stage, the 18-stage dividers, the
//  select stage and the three blend stages
//  mode none (and the unused codes) gives no done pulse
//  rst is synchronous and clears every stage valid bit; the result side has
//  no stall, each done beat lasts one cycle
// ----------------------------------------------------------------------------
`include "gradient_fill_pixel_generator_assert.svh"

module gradient_fill_pixel_generator #(
  parameter int MAX_DIM = gfpg_pkg::GFPG_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gfpg_pkg::pixel_t            pixel,
  output logic                        done,
  output gfpg_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfpg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gfpg_pkg::*;

  localparam int CAP_INT = (MAX_DIM > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1 : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(CAP_INT);
  localparam int DEN_W = RS_W + DIM_W;
  localparam int RAD_W = 60;
  localparam int ROOT_W = RAD_W / 2;
  localparam int LN_W = COORD_W + 16;
  localparam int RN_W = ROOT_W + 12;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  cfg_t cfg;

  logic [DIM_W-1:0] w_eff, h_eff, span_x, span_y;
  logic [DEN_W-1:0] den_rad;

  logic               v1;
  logic [COORD_W-1:0] x1, y1;
  logic               v2;
  logic [DIM_W-1:0]   dx2, dy2;
  logic [LN_W-1:0]    xn2, yn2;
  logic               v3;
  logic [2*DIM_W-1:0] sqx3, sqy3;
  logic [LN_W-1:0]    xn3, yn3;

  logic [COORD_W-1:0] xs, ys;
  logic [DIM_W-1:0]   tx, ty;

  logic                sq_valid;
  logic [ROOT_W-1:0]   root;
  logic [2*LN_W-1:0]   sq_side;
  logic [2*DIM_W:0]    qsum;

  logic               vr;
  logic [RN_W-1:0]    rn_r;
  logic [LN_W-1:0]    xn_r, yn_r;

  logic               dv;
  logic               dvx, dvy;
  logic [FRAC_W-1:0]  qx, qy, qr;
  logic               ox, oy, orad;

  logic               sel_valid;
  logic [FRAC_W-1:0]  fx, fy, fr;

  assign busy = 1'b0;

  gfpg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // frame values derived from the registers
  always_ff @(posedge clk) begin
    w_eff   <= clamp_dim(cfg.frame_width);
    h_eff   <= clamp_dim(cfg.frame_height);
    span_x  <= clamp_dim(cfg.frame_width) - DIM_W'(1);
    span_y  <= clamp_dim(cfg.frame_height) - DIM_W'(1);
    den_rad <= DEN_W'(cfg.radius_scale) * DEN_W'(clamp_dim(cfg.frame_width));
  end

  // saturate and centre offset
  always_comb begin
    xs = ({1'b0, x1} > span_x) ? span_x[COORD_W-1:0] : x1;
    ys = ({1'b0, y1} > span_y) ? span_y[COORD_W-1:0] : y1;
    tx = {xs, 1'b0};
    ty = {ys, 1'b0};
  end

  // front stages: capture, offsets, squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy && mode_active(cfg.mode);
      v2 <= v1;
      v3 <= v2;
    end
    x1   <= pixel.pixel_x;
    y1   <= pixel.pixel_y;
    dx2  <= (tx >= w_eff) ? tx - w_eff : w_eff - tx;
    dy2  <= (ty >= h_eff) ? ty - h_eff : h_eff - ty;
    xn2  <= {xs, 16'h0000} + LN_W'(span_x[DIM_W-1:1]);
    yn2  <= {ys, 16'h0000} + LN_W'(span_y[DIM_W-1:1]);
    sqx3 <= (2*DIM_W)'(dx2) * (2*DIM_W)'(dx2);
    sqy3 <= (2*DIM_W)'(dy2) * (2*DIM_W)'(dy2);
    xn3  <= xn2;
    yn3  <= yn2;
  end

  assign qsum = (2*DIM_W+1)'(sqx3) + (2*DIM_W+1)'(sqy3);

  gfpg_sqrt #(.RW(RAD_W), .SW(2*LN_W)) u_sqrt (
    .clk, .rst,
    .in_valid  (v3),
    .radicand  ({1'b0, qsum, 32'h0000_0000}),
    .in_side   ({xn3, yn3}),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (sq_side)
  );

  // radial numerator with half-divisor rounding
  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else     vr <= sq_valid;
    rn_r <= RN_W'({root, 11'h000}) + RN_W'(den_rad[DEN_W-1:1]);
    xn_r <= sq_side[2*LN_W-1:LN_W];
    yn_r <= sq_side[LN_W-1:0];
  end

  gfpg_div #(.NW(RN_W), .DW(DEN_W), .QW(FRAC_W)) u_div_rad (
    .clk, .rst, .in_valid(vr), .num(rn_r), .den(den_rad),
    .out_valid(dv), .quot(qr), .ovf(orad)
  );

  gfpg_div #(.NW(LN_W), .DW(DIM_W), .QW(FRAC_W)) u_div_x (
    .clk, .rst, .in_valid(vr), .num(xn_r), .den(span_x),
    .out_valid(dvx), .quot(qx), .ovf(ox)
  );

  gfpg_div #(.NW(LN_W), .DW(DIM_W), .QW(FRAC_W)) u_div_y (
    .clk, .rst, .in_valid(vr), .num(yn_r), .den(span_y),
    .out_valid(dvy), .quot(qy), .ovf(oy)
  );

  // fraction select and saturation
  always_ff @(posedge clk) begin
    if (rst) sel_valid <= 1'b0;
    else     sel_valid <= dv && dvx && dvy;
    fx <= (span_x == '0 || ox) ? '0 : qx;
    fy <= (span_y == '0 || oy) ? '0 : qy;
    fr <= (cfg.radius_scale == '0 || orad || qr > FRAC_ONE) ? FRAC_ONE : qr;
  end

  gfpg_blend u_blend (
    .clk, .rst, .in_valid(sel_valid), .fx, .fy, .fr, .cfg, .done, .result
  );

  // checks
  `GFPG_ASSERT(a_sel_done, sel_valid |-> ##3 done, "blend lost a beat")
  `GFPG_ASSERT(a_done_mode, done |-> mode_active(cfg.mode), "pixel in inactive mode")
  `GFPG_ASSERT(a_lin_range, dvx && span_x != '0 |-> qx <= FRAC_ONE, "x fraction above one")

endmodule
